FILE: hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; imported by every module of the block but lfu_entry_ram.
`timescale 1ns / 1ps

package lfu_pkg;

    // Configuration register width and reset value
    localparam int unsigned CFG_W = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Use counter width and its saturation value
    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_ONE = 16'd1;

    // Operation codes carried on tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Update command for the per-entry metadata lanes
    typedef struct packed {
        logic en;         // apply an update this cycle
        logic age_all;    // age every valid entry (fresh insert into a free slot)
        logic cnt_reset;  // slot count restarts at one instead of bumping
    } t_meta_op;

    // Flags gathered by the scan
    typedef struct packed {
        logic found;        // key present
        logic have_victim;  // at least one valid entry seen
        logic have_free;    // at least one empty slot seen
    } t_scan_res;

endpackage

FILE: hw/rtl/lfu_cache_table_core.sv
// LFU cache table top level: sequencer, config register and output register.
// Depends on lfu_pkg, lfu_entry_ram, lfu_meta_regs, lfu_scan_unit.
//
// Channel   Dir  Accept on                   Payload
// s_axis    in   tvalid & tready             tuser: cmd; tdata: lookup_key, store_value
// m_axis    out  tvalid & tready             tuser: hit, evicted; tdata: read_value, evicted_key
// cfg       in   i_cfg_we                    cap_in_use (5 bits)
//
// An item passes through the idle state that accepts it, a registered key/value memory
// read, a compare of every entry in turn (one entry per cycle) and an update state, so
// no new item is taken before the last is through. tready is high only in the idle state.
// The update waits while the output register still holds an untaken result.
// Reset (synchronous, active low) clears valid bits, sets cap_in_use to 16; no sweep.
`timescale 1ns / 1ps

module lfu_cache_table_core #(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32,
    localparam int unsigned IN_W  = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((VALUE_WIDTH + KEY_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // lookup_key, store_value
    input  logic             i_s_axis_tuser,   // cmd
    // result items
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // read_value, evicted_key
    output logic [1:0]       o_m_axis_tuser,   // hit, evicted
    // configuration
    input  logic             i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wdata
);

    import lfu_pkg::*;

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int unsigned DW    = KEY_WIDTH + VALUE_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    t_state n_state, r_state;

    logic [CFG_W-1:0]       r_cap;
    logic                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_val;

    logic [IDX_W-1:0] r_ptr;
    logic             r_issue;
    logic             r_chk_vld;
    logic [IDX_W-1:0] r_chk_idx;

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic                   r_out_ev;
    logic [VALUE_WIDTH-1:0] r_out_val;
    logic [KEY_WIDTH-1:0]   r_out_evk;

    logic in_fire, upd_fire, scan_done;

    logic [DW-1:0]          ram_rdata;
    logic                   ram_we;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       pivot;
    t_meta_op               meta_op;

    logic                   md_valid;
    logic [CNT_W-1:0]       md_count;
    logic [IDX_W-1:0]       md_rank;

    t_scan_res              sres;
    logic [IDX_W-1:0]       found_idx, found_rank, victim_idx, victim_rank, free_idx;
    logic [VALUE_WIDTH-1:0] found_val;
    logic [KEY_WIDTH-1:0]   victim_key;
    logic [OCC_W-1:0]       used;

    logic [CMP_W-1:0]       cap_ext, cap_eff;
    logic                   is_put, cap_zero, full, do_evict;
    logic                   res_ev;
    logic [VALUE_WIDTH-1:0] res_val;
    logic [KEY_WIDTH-1:0]   res_evk;

    // Handshake events
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign upd_fire  = (r_state == ST_UPDATE) && (!r_out_valid || i_m_axis_tready);
    assign scan_done = r_chk_vld && (r_chk_idx == LAST_IDX);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire)   n_state = ST_SCAN;
            ST_SCAN:   if (scan_done) n_state = ST_UPDATE;
            ST_UPDATE: if (upd_fire)  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State-decoded outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE:   o_s_axis_tready = 1'b1;
            ST_SCAN:   o_s_axis_tready = 1'b0;
            ST_UPDATE: o_s_axis_tready = 1'b0;
            default:   o_s_axis_tready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_issue     <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // scan address sequencer
            if (in_fire) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_ptr == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
            r_chk_vld <= r_issue;
            // output register
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_s_axis_tuser;
            r_key <= i_s_axis_tdata[0 +: KEY_WIDTH];
            r_val <= i_s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH];
            r_ptr <= '0;
        end else if (r_issue) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        r_chk_idx <= r_ptr;
        if (upd_fire) begin
            r_out_hit <= sres.found;
            r_out_ev  <= res_ev;
            r_out_val <= res_val;
            r_out_evk <= res_evk;
        end
    end

    // Key/value memory: word holds value above key
    lfu_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata ({r_val, r_key}),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    lfu_meta_regs #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_meta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_chk_idx),
        .o_rd_valid (md_valid),
        .o_rd_count (md_count),
        .o_rd_rank  (md_rank),
        .i_op       (meta_op),
        .i_slot     (slot),
        .i_pivot    (pivot)
    );

    lfu_scan_unit #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .OCC_W       (OCC_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_clr         (in_fire),
        .i_chk         (r_chk_vld),
        .i_chk_idx     (r_chk_idx),
        .i_valid       (md_valid),
        .i_count       (md_count),
        .i_rank        (md_rank),
        .i_entry_key   (ram_rdata[0 +: KEY_WIDTH]),
        .i_entry_val   (ram_rdata[KEY_WIDTH +: VALUE_WIDTH]),
        .i_key         (r_key),
        .o_res         (sres),
        .o_found_idx   (found_idx),
        .o_found_rank  (found_rank),
        .o_found_val   (found_val),
        .o_victim_idx  (victim_idx),
        .o_victim_rank (victim_rank),
        .o_victim_key  (victim_key),
        .o_free_idx    (free_idx),
        .o_used        (used)
    );

    // Capacity in use, clipped to the storage depth
    assign cap_ext  = CMP_W'(r_cap);
    assign cap_eff  = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
    assign is_put   = (r_cmd == CMD_PUT);
    assign cap_zero = (r_cap == '0);
    assign full     = (CMP_W'(used) >= cap_eff);
    assign do_evict = is_put && !cap_zero && !sres.found && full;

    // Update decision: hit touches, eviction reuses the victim slot, else first free slot; zero capacity ignores puts
    always_comb begin
        meta_op = '0;
        ram_we  = 1'b0;
        slot    = found_idx;
        pivot   = found_rank;
        if (sres.found) begin
            if (!is_put || !cap_zero) begin
                meta_op.en = upd_fire;
                ram_we     = upd_fire && is_put;
            end
        end else if (is_put && !cap_zero) begin
            meta_op.en        = upd_fire;
            meta_op.cnt_reset = 1'b1;
            ram_we            = upd_fire;
            if (full) begin
                slot  = victim_idx;
                pivot = victim_rank;
            end else begin
                slot              = free_idx;
                meta_op.age_all   = 1'b1;
            end
        end
    end

    // Result fields
    assign res_ev  = do_evict;
    assign res_val = (sres.found && !is_put) ? found_val : '0;
    assign res_evk = do_evict ? victim_key : '0;

    // Output packing
    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[0 +: VALUE_WIDTH]         = r_out_val;
        o_m_axis_tdata[VALUE_WIDTH +: KEY_WIDTH] = r_out_evk;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out_ev, r_out_hit};

endmodule

FILE: hw/rtl/lfu_entry_ram.sv
// Key/value storage memory: one write port, one registered read port.
// Depends on nothing; used by lfu_cache_table_core.
`timescale 1ns / 1ps

module lfu_entry_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lfu_meta_regs.sv
// Per-entry valid bits, use counts and recency ranks, held in lanes.
// Depends on lfu_pkg; used by lfu_cache_table_core.
`timescale 1ns / 1ps

module lfu_meta_regs #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned IDX_W    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // scan read port
    input  logic [IDX_W-1:0]       i_rd_idx,
    output logic                   o_rd_valid,
    output logic [lfu_pkg::CNT_W-1:0] o_rd_count,
    output logic [IDX_W-1:0]       o_rd_rank,
    // update port
    input  lfu_pkg::t_meta_op      i_op,
    input  logic [IDX_W-1:0]       i_slot,
    input  logic [IDX_W-1:0]       i_pivot
);

    import lfu_pkg::*;

    logic             r_valid [CAPACITY];
    logic [CNT_W-1:0] r_count [CAPACITY];
    logic [IDX_W-1:0] r_rank  [CAPACITY];

    // Valid bits: cleared at reset, set when a slot is written
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_op.en && (IDX_W'(i) == i_slot)) begin
                r_valid[i] <= 1'b1;
            end
        end
    end

    // Count and rank lanes: the slot becomes most recent, younger entries (all others on a fresh insert) age by one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_op.en) begin
                if (IDX_W'(i) == i_slot) begin
                    r_rank[i] <= '0;
                    if (i_op.cnt_reset) begin
                        r_count[i] <= CNT_ONE;
                    end else if (r_count[i] != CNT_MAX) begin
                        r_count[i] <= r_count[i] + CNT_ONE;
                    end
                end else if (r_valid[i] && (i_op.age_all || (r_rank[i] < i_pivot))) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
        end
    end

    // Read for the scan unit
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_count = r_count[i_rd_idx];
    assign o_rd_rank  = r_rank[i_rd_idx];

endmodule

FILE: hw/rtl/lfu_scan_unit.sv
// Shared compare unit: one entry per cycle, tracks hit, LFU/LRU victim,
// first free slot and occupancy. Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_scan_unit #(
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned IDX_W       = 4,
    parameter int unsigned OCC_W       = 5
) (
    input  logic                      i_clk,
    input  logic                      i_clr,
    input  logic                      i_chk,
    input  logic [IDX_W-1:0]          i_chk_idx,
    input  logic                      i_valid,
    input  logic [lfu_pkg::CNT_W-1:0] i_count,
    input  logic [IDX_W-1:0]          i_rank,
    input  logic [KEY_WIDTH-1:0]      i_entry_key,
    input  logic [VALUE_WIDTH-1:0]    i_entry_val,
    input  logic [KEY_WIDTH-1:0]      i_key,
    output lfu_pkg::t_scan_res        o_res,
    output logic [IDX_W-1:0]          o_found_idx,
    output logic [IDX_W-1:0]          o_found_rank,
    output logic [VALUE_WIDTH-1:0]    o_found_val,
    output logic [IDX_W-1:0]          o_victim_idx,
    output logic [IDX_W-1:0]          o_victim_rank,
    output logic [KEY_WIDTH-1:0]      o_victim_key,
    output logic [IDX_W-1:0]          o_free_idx,
    output logic [OCC_W-1:0]          o_used
);

    import lfu_pkg::*;

    t_scan_res        r_res;
    logic [IDX_W-1:0] r_found_idx;
    logic [IDX_W-1:0] r_found_rank;
    logic [VALUE_WIDTH-1:0] r_found_val;
    logic [IDX_W-1:0] r_victim_idx;
    logic [IDX_W-1:0] r_victim_rank;
    logic [CNT_W-1:0] r_victim_cnt;
    logic [KEY_WIDTH-1:0] r_victim_key;
    logic [IDX_W-1:0] r_free_idx;
    logic [OCC_W-1:0] r_used;

    logic take_victim;

    // Smaller count wins; on equal count the older (higher rank) entry wins
    assign take_victim = !r_res.have_victim || (i_count < r_victim_cnt) ||
                         ((i_count == r_victim_cnt) && (i_rank > r_victim_rank));

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_res  <= '0;
            r_used <= '0;
        end else if (i_chk) begin
            if (i_valid) begin
                r_used <= r_used + OCC_W'(1);
                if (i_entry_key == i_key) begin
                    r_res.found  <= 1'b1;
                    r_found_idx  <= i_chk_idx;
                    r_found_rank <= i_rank;
                    r_found_val  <= i_entry_val;
                end
                if (take_victim) begin
                    r_res.have_victim <= 1'b1;
                    r_victim_idx      <= i_chk_idx;
                    r_victim_rank     <= i_rank;
                    r_victim_cnt      <= i_count;
                    r_victim_key      <= i_entry_key;
                end
            end else if (!r_res.have_free) begin
                r_res.have_free <= 1'b1;
                r_free_idx      <= i_chk_idx;
            end
        end
    end

    assign o_res         = r_res;
    assign o_found_idx   = r_found_idx;
    assign o_found_rank  = r_found_rank;
    assign o_found_val   = r_found_val;
    assign o_victim_idx  = r_victim_idx;
    assign o_victim_rank = r_victim_rank;
    assign o_victim_key  = r_victim_key;
    assign o_free_idx    = r_free_idx;
    assign o_used        = r_used;

endmodule

FILE: dv/lfu_cache_table_core_test.sv
// Self-checking testbench for lfu_cache_table_core: an LFU/LRU predictor checks every result.
// Depends on lfu_pkg and lfu_cache_table_core; it drives the item streams and the capacity register.
`timescale 1ns / 1ps

module lfu_cache_table_core_test;
    import lfu_pkg::*;

    localparam int unsigned NSLOTS     = 16;
    localparam int unsigned TIMEOUT_NS = 10_000_000;
    localparam int unsigned MAX_SHOWN  = 10;
    localparam int unsigned POOL_SIZE  = 24;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] value;
    } t_cache_op;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_cache_reply;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stimulus-side signals
    logic              op_valid = 1'b0;
    logic              op_cmd   = CMD_GET;
    logic [31:0]       op_key   = '0;
    logic [31:0]       op_value = '0;
    logic              reply_ready = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [63:0]       o_m_axis_tdata;
    logic [1:0]        o_m_axis_tuser;

    lfu_cache_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (op_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({op_value, op_key}),
        .i_s_axis_tuser  (op_cmd),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (reply_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Traffic shaping, percent per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    t_cache_op    pending_ops[$];
    t_cache_reply expected_replies[$];
    logic [31:0]  key_pool[POOL_SIZE];

    int unsigned mismatches   = 0;
    int unsigned replies_seen = 0;
    int unsigned hits_seen    = 0;
    int unsigned evicts_seen  = 0;
    int unsigned cap_settings = 0;

    // Predicted cache contents
    logic [CFG_W-1:0] cap_setting = CAP_RESET;
    logic             slot_valid[NSLOTS];
    logic [31:0]      slot_key[NSLOTS];
    logic [31:0]      slot_value[NSLOTS];
    logic [CNT_W-1:0] slot_uses[NSLOTS];
    logic [3:0]       slot_age[NSLOTS];

    // Move a slot to most recent; younger entries age by one, count saturates
    function automatic void promote_slot(input int s);
        logic [3:0] r;
        r = slot_age[s];
        for (int i = 0; i < NSLOTS; i++)
            if (slot_valid[i] && i != s && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = '0;
        if (slot_uses[s] < CNT_MAX)
            slot_uses[s]++;
    endfunction

    // Apply one operation to the predicted contents and return its reply
    function automatic t_cache_reply predict_reply(input t_cache_op op);
        t_cache_reply res;
        int           found;
        int           victim;
        int           slot;
        int unsigned  used;
        int unsigned  cap;
        logic [3:0]   vage;
        res    = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        used   = 0;
        cap    = (cap_setting > NSLOTS) ? NSLOTS : cap_setting;

        for (int i = 0; i < NSLOTS; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (slot_key[i] == op.key)
                    found = i;
            end
        end
        res.hit = (found >= 0);

        if (op.cmd == CMD_GET) begin
            if (found >= 0) begin
                res.read_value = slot_value[found];
                promote_slot(found);
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                promote_slot(found);
                slot_value[found] = op.value;
            end else begin
                // Full: lowest count loses, oldest among equal counts
                if (used >= cap) begin
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (!slot_valid[i])
                            continue;
                        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                            (slot_uses[i] == slot_uses[victim] &&
                             slot_age[i] > slot_age[victim]))
                            victim = i;
                    end
                end
                if (victim >= 0) begin
                    vage            = slot_age[victim];
                    res.evicted     = 1'b1;
                    res.evicted_key = slot_key[victim];
                    slot_valid[victim] = 1'b0;
                    for (int i = 0; i < NSLOTS; i++)
                        if (slot_valid[i] && slot_age[i] > vage)
                            slot_age[i]--;
                    slot = victim;
                end else begin
                    for (int i = 0; i < NSLOTS; i++)
                        if (!slot_valid[i] && slot < 0)
                            slot = i;
                end
                if (slot >= 0) begin
                    for (int i = 0; i < NSLOTS; i++)
                        if (slot_valid[i])
                            slot_age[i]++;
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = op.key;
                    slot_value[slot] = op.value;
                    slot_uses[slot]  = CNT_ONE;
                    slot_age[slot]   = '0;
                end
            end
        end
        return res;
    endfunction

    // Driver: predicts on acceptance, then presents the next pending item
    always @(posedge i_clk) begin
        t_cache_op    nxt;
        t_cache_op    cur;
        t_cache_reply pred;
        if (!i_rst_n) begin
            op_valid <= 1'b0;
        end else begin
            if (op_valid && o_s_axis_tready) begin
                cur.cmd   = op_cmd;
                cur.key   = op_key;
                cur.value = op_value;
                pred      = predict_reply(cur);
                expected_replies.insert(expected_replies.size(), pred);
            end
            if (!op_valid || o_s_axis_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_ops[0];
                    pending_ops.delete(0);
                    op_valid <= 1'b1;
                    op_cmd   <= nxt.cmd;
                    op_key   <= nxt.key;
                    op_value <= nxt.value;
                end else begin
                    op_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        reply_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected %08h, got %08h",
                     $realtime, what, want, got);
    endtask

    // Monitor: compare each accepted reply with the oldest prediction
    always @(posedge i_clk) begin
        t_cache_reply want;
        t_cache_reply got;
        if (i_rst_n && o_m_axis_tvalid && reply_ready) begin
            got.hit         = o_m_axis_tuser[0];
            got.evicted     = o_m_axis_tuser[1];
            got.read_value  = o_m_axis_tdata[31:0];
            got.evicted_key = o_m_axis_tdata[63:32];
            if (expected_replies.size() == 0) begin
                flag_mismatch("unexpected reply (read_value)", '0, got.read_value);
            end else begin
                want = expected_replies[0];
                expected_replies.delete(0);
                replies_seen++;
                if (want.hit)
                    hits_seen++;
                if (want.evicted)
                    evicts_seen++;
                if (got.hit !== want.hit)
                    flag_mismatch("hit", 32'(want.hit), 32'(got.hit));
                if (got.read_value !== want.read_value)
                    flag_mismatch("read_value", want.read_value, got.read_value);
                if (got.evicted !== want.evicted)
                    flag_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
                if (got.evicted_key !== want.evicted_key)
                    flag_mismatch("evicted_key", want.evicted_key, got.evicted_key);
            end
        end
    end

    task automatic queue_op(input logic cmd, input logic [31:0] key, input logic [31:0] value);
        t_cache_op op;
        op.cmd   = cmd;
        op.key   = key;
        op.value = value;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // Skewed key choice so some keys are hot, a few keys are fresh
    task automatic queue_random_ops(input int unsigned n);
        logic [31:0] key;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
            queue_op($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, $urandom);
        end
    endtask

    // Block until every item is taken and every reply has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || op_valid || expected_replies.size() != 0);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        @(posedge i_clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= cap;
        cap_setting  = cap;
        cap_settings++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cap, input int unsigned idle_pct,
                             input int unsigned stall_pct, input int unsigned n);
        wait_drained();
        write_capacity(cap);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        queue_random_ops(n);
    endtask

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
            slot_age[i]   = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Capacity above the table size acts as full size; extreme keys and values
        write_capacity(5'd31);
        queue_op(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(CMD_GET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        queue_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        queue_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
        queue_op(CMD_PUT, 32'h0000_0002, 32'h5A5A_5A5A);

        // Capacity dropped below occupancy: each new key evicts one entry
        wait_drained();
        write_capacity(5'd2);
        queue_op(CMD_PUT, 32'h0000_0003, 32'h0000_0033);
        queue_op(CMD_GET, 32'h0000_0003, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h0000_0004, 32'h0000_0044);
        queue_op(CMD_PUT, 32'h0000_0005, 32'h0000_0055);

        // Capacity zero: puts are ignored but lookups still hit
        wait_drained();
        write_capacity(5'd0);
        queue_op(CMD_PUT, 32'h0000_0009, 32'h0000_0099);
        queue_op(CMD_PUT, 32'h0000_0005, 32'hDEAD_BEEF);
        queue_op(CMD_GET, 32'h0000_0005, 32'h0000_0000);
        queue_op(CMD_GET, 32'h0000_0009, 32'h0000_0000);

        // Random traffic under the different idle patterns
        run_phase(5'd16, 0, 0, 200);
        run_phase(5'd4, 78, 0, 200);
        run_phase(5'd1, 0, 78, 150);
        run_phase(5'd0, 15, 15, 100);
        run_phase(5'd16, 15, 15, 125);
        wait_drained();
        queue_random_ops(125);
        run_phase(5'd8, 78, 0, 200);
        run_phase(5'd31, 0, 78, 200);

        wait_drained();
        repeat (4 * (NSLOTS + 2)) @(posedge i_clk);
        if (expected_replies.size() != 0)
            mismatches += expected_replies.size();

        $display("Checked %0d replies (%0d hits, %0d evictions) over %0d capacity settings,",
                 replies_seen, hits_seen, evicts_seen, cap_settings);
        $display("with sender gaps, receiver stalls, both, none, and a full drain mid-stream.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_entry_ram.sv
hw/rtl/lfu_meta_regs.sv
hw/rtl/lfu_scan_unit.sv
hw/rtl/lfu_cache_table_core.sv
dv/lfu_cache_table_core_test.sv
